// File: hdl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg: shared types, constants and microprogram for the display smoother
// Holds the control word format, the step program ROM and the config bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int PctW    = 7;
  localparam int TimeW   = 32;
  localparam int GainW   = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 32;
  localparam int StepW   = 3;
  localparam int ProdW   = PctW + GainW;   // |delta| * numerator
  localparam int CntW    = 4;
  localparam int DivBits = ProdW;          // one quotient bit per step

  localparam logic [PctW-1:0] PctMax = PctW'(100);

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SNAP_INTERVAL = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_DANGER_LEVEL  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_GAIN_NUM      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] REG_GAIN_DEN      = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] REG_MAX_STEP      = CfgIdxW'(4);

  // program addresses
  localparam logic [StepW-1:0] ST_WAIT   = StepW'(0);
  localparam logic [StepW-1:0] ST_SEED   = StepW'(1);
  localparam logic [StepW-1:0] ST_DANGER = StepW'(2);
  localparam logic [StepW-1:0] ST_MUL    = StepW'(3);
  localparam logic [StepW-1:0] ST_DIV    = StepW'(4);
  localparam logic [StepW-1:0] ST_ADJ    = StepW'(5);
  localparam logic [StepW-1:0] ST_SNAP   = StepW'(6);
  localparam logic [StepW-1:0] ST_EMIT   = StepW'(7);

  typedef enum logic [2:0] {
    OP_CAPTURE,
    OP_NOP,
    OP_MUL,
    OP_DIV,
    OP_ADJ,
    OP_SNAP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_SNAP,
    C_DANGER,
    C_DIV_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic snap;
    logic danger;
    logic div_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [TimeW-1:0] snap_interval_ms;
    logic [PctW-1:0]  danger_level;
    logic [GainW-1:0] gain_numerator;
    logic [GainW-1:0] gain_denominator;
    logic [PctW-1:0]  max_step;
  } cfg_t;

  // Microprogram. Fall-through goes to the next address; the last step
  // wraps back to the wait step.
  function automatic ctrl_t rom(input logic [StepW-1:0] addr);
    ctrl_t w;
    case (addr)
      ST_WAIT:   w = '{OP_CAPTURE, C_NO_IN,    ST_WAIT};
      ST_SEED:   w = '{OP_NOP,     C_SNAP,     ST_SNAP};
      ST_DANGER: w = '{OP_NOP,     C_DANGER,   ST_SNAP};
      ST_MUL:    w = '{OP_MUL,     C_NEVER,    ST_WAIT};
      ST_DIV:    w = '{OP_DIV,     C_DIV_MORE, ST_DIV};
      ST_ADJ:    w = '{OP_ADJ,     C_ALWAYS,   ST_EMIT};
      ST_SNAP:   w = '{OP_SNAP,    C_NEVER,    ST_WAIT};
      ST_EMIT:   w = '{OP_EMIT,    C_OUT_BUSY, ST_EMIT};
      default:   w = '{OP_NOP,     C_ALWAYS,   ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/percent_display_smoother_unit.sv
// ----------------------------------------------------------------------------
// percent_display_smoother_unit: slew-limited smoothing of a battery percentage
// Microcoded sequencer over a small datapath; config registers live here.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | input     | in_valid/in_ready   | raw_percent[6:0], time_ms[31:0]
//   out     | output    | out_valid/out_ready | shown_percent[6:0]
//   cfg     | input     | cfg_we (no wait)    | cfg_index[2:0], cfg_data[31:0]
//
// Flow: one item at a time. Snap path: accept, snap test, snap load, then
//   emit (result register load). Danger bypass: the danger test before snap
//   load. Smoothing: multiply, one-bit-per-step restoring divider, clamp, emit.
// Reset: rst is synchronous; it restores the config defaults, clears the
//   seeded flag, stored timestamp and displayed value, and the step counter.
// Stalls: the result sits in its own register; the emit step waits only if
//   that register is still full, so the next item can be computed meanwhile.
//
`default_nettype none

module percent_display_smoother_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pds_pkg::PctW-1:0]      raw_percent,
  input  wire logic [pds_pkg::TimeW-1:0]     time_ms,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pds_pkg::PctW-1:0]           shown_percent,
  input  wire logic                          cfg_we,
  input  wire logic [pds_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [pds_pkg::CfgDatW-1:0]   cfg_data
);

  pds_pkg::cfg_t    cfg;
  pds_pkg::op_t     op;
  pds_pkg::status_t status;

  // Config registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.snap_interval_ms <= pds_pkg::TimeW'(60000);
      cfg.danger_level     <= pds_pkg::PctW'(10);
      cfg.gain_numerator   <= pds_pkg::GainW'(1);
      cfg.gain_denominator <= pds_pkg::GainW'(4);
      cfg.max_step         <= pds_pkg::PctW'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        pds_pkg::REG_SNAP_INTERVAL: cfg.snap_interval_ms <= cfg_data[pds_pkg::TimeW-1:0];
        pds_pkg::REG_DANGER_LEVEL:  cfg.danger_level     <= cfg_data[pds_pkg::PctW-1:0];
        pds_pkg::REG_GAIN_NUM:      cfg.gain_numerator   <= cfg_data[pds_pkg::GainW-1:0];
        pds_pkg::REG_GAIN_DEN:      cfg.gain_denominator <= cfg_data[pds_pkg::GainW-1:0];
        pds_pkg::REG_MAX_STEP:      cfg.max_step         <= cfg_data[pds_pkg::PctW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Step program: wait/capture, snap test, danger test, multiply,
  // divide loop, clamp and apply, snap load, emit.
  pds_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  pds_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_percent   (raw_percent),
    .time_ms       (time_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .shown_percent (shown_percent),
    .status        (status)
  );

endmodule

`default_nettype wire

// File: hdl/pds_sequencer.sv
// ----------------------------------------------------------------------------
// pds_sequencer: step counter and control ROM
// Fetches one control word per cycle and resolves conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_sequencer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pds_pkg::status_t  status,
  output pds_pkg::op_t           op
);

  logic [pds_pkg::StepW-1:0] step;
  logic [pds_pkg::StepW-1:0] step_next;
  pds_pkg::ctrl_t            word;
  logic                      take;

  assign word = pds_pkg::rom(step);
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      pds_pkg::C_NEVER:    take = 1'b0;
      pds_pkg::C_ALWAYS:   take = 1'b1;
      pds_pkg::C_NO_IN:    take = ~status.in_fire;
      pds_pkg::C_SNAP:     take = status.snap;
      pds_pkg::C_DANGER:   take = status.danger;
      pds_pkg::C_DIV_MORE: take = status.div_more;
      pds_pkg::C_OUT_BUSY: take = status.out_busy;
      default:             take = 1'b1;
    endcase
    // natural wrap of the last address returns to the wait step
    step_next = take ? word.target : step + pds_pkg::StepW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= pds_pkg::ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pds_datapath.sv
// ----------------------------------------------------------------------------
// pds_datapath: smoothing datapath driven by the microcode op
// Capture, gap test, multiply, restoring divide, step clamp, snap load and output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pds_pkg::op_t                op,
  input  wire pds_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pds_pkg::PctW-1:0]    raw_percent,
  input  wire logic [pds_pkg::TimeW-1:0]   time_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pds_pkg::PctW-1:0]         shown_percent,
  output pds_pkg::status_t                 status
);

  localparam int PctW  = pds_pkg::PctW;
  localparam int ProdW = pds_pkg::ProdW;
  localparam int GainW = pds_pkg::GainW;
  localparam int CntW  = pds_pkg::CntW;

  logic                      seeded;
  logic [pds_pkg::TimeW-1:0] prior_time;
  logic [PctW-1:0]           shown;
  logic [PctW-1:0]           raw;
  logic                      snap_flag;
  logic                      neg;
  logic                      delta_nz;
  logic [ProdW-1:0]          dvd;      // dividend, becomes quotient
  logic [GainW-1:0]          rem;
  logic [CntW-1:0]           cnt;
  logic [PctW-1:0]           out_data;

  logic                      in_fire;
  logic [pds_pkg::TimeW-1:0] gap_ms;
  logic [PctW-1:0]           raw_sat;
  logic [PctW-1:0]           mag;
  logic [GainW-1:0]          den;
  logic [GainW:0]            trial;
  logic                      qbit;
  logic [PctW-1:0]           stepm;
  logic [PctW:0]             sum;
  logic [PctW-1:0]           shown_adj;

  assign in_ready = (op == pds_pkg::OP_CAPTURE);
  assign in_fire  = in_valid & in_ready;
  assign gap_ms   = time_ms - prior_time;
  assign raw_sat  = (raw > pds_pkg::PctMax) ? pds_pkg::PctMax : raw;
  assign mag      = (raw < shown) ? (shown - raw) : (raw - shown);
  assign den      = (cfg.gain_denominator == '0) ? GainW'(1) : cfg.gain_denominator;
  assign trial    = {rem, dvd[ProdW-1]};
  assign qbit     = (trial >= {1'b0, den});

  // step magnitude: nudge to one, then clamp to the limit
  always_comb begin
    if (dvd == '0) begin
      stepm = delta_nz ? PctW'(1) : '0;
    end else if (dvd > ProdW'(cfg.max_step)) begin
      stepm = cfg.max_step;
    end else begin
      stepm = dvd[PctW-1:0];
    end
    if (cfg.max_step < stepm) begin
      stepm = cfg.max_step;
    end
    sum = {1'b0, shown} + {1'b0, stepm};
    if (neg) begin
      shown_adj = (stepm > shown) ? '0 : (shown - stepm);
    end else begin
      shown_adj = (sum > {1'b0, pds_pkg::PctMax}) ? pds_pkg::PctMax : sum[PctW-1:0];
    end
  end

  assign status.in_fire  = in_fire;
  assign status.snap     = snap_flag;
  assign status.danger   = (raw <= cfg.danger_level);
  assign status.div_more = (cnt != CntW'(1));
  assign status.out_busy = out_valid & ~out_ready;

  assign shown_percent = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded     <= 1'b0;
      prior_time <= '0;
      shown      <= '0;
      out_valid  <= 1'b0;
    end else begin
      // emit loads a new item; otherwise a taken item empties the register
      if (op == pds_pkg::OP_EMIT && !status.out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        pds_pkg::OP_CAPTURE: begin
          if (in_fire) begin
            raw        <= raw_percent;
            prior_time <= time_ms;
            snap_flag  <= ~seeded | (gap_ms > cfg.snap_interval_ms);
          end
        end
        pds_pkg::OP_MUL: begin
          neg      <= (raw < shown);
          delta_nz <= (mag != '0);
          dvd      <= ProdW'(mag) * ProdW'(cfg.gain_numerator);
          rem      <= '0;
          cnt      <= CntW'(pds_pkg::DivBits);
        end
        pds_pkg::OP_DIV: begin
          rem <= qbit ? GainW'(trial - {1'b0, den}) : trial[GainW-1:0];
          dvd <= {dvd[ProdW-2:0], qbit};
          cnt <= cnt - CntW'(1);
        end
        pds_pkg::OP_ADJ: begin
          shown <= shown_adj;
        end
        pds_pkg::OP_SNAP: begin
          shown  <= raw_sat;
          seeded <= 1'b1;
        end
        pds_pkg::OP_EMIT: begin
          if (!status.out_busy) begin
            out_data <= shown;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/pds_checker.sv
// ----------------------------------------------------------------------------
// pds_checker: port-level assertions for the display smoother
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pds_pkg::PctW-1:0]    shown_percent
);

  // a pending result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(shown_percent))
    else $error("result changed or dropped while stalled");

  // displayed value is always saturated
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> shown_percent <= pds_pkg::PctMax)
    else $error("shown_percent above 100");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind percent_display_smoother_unit pds_checker u_pds_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .shown_percent (shown_percent)
);

`default_nettype wire

// File: bench/percent_display_smoother_unit_tb.sv
// ----------------------------------------------------------------------------
// percent_display_smoother_unit_tb: self-checking bench for the display smoother
// Walks a directed table of items and register writes, then runs random phases
// of timestamped readings under random settings. Every shown_percent item is checked
// against a pinned value or an in-bench model of the smoothing, snap and bypass rules.
// ----------------------------------------------------------------------------

module percent_display_smoother_unit_tb;

  localparam int CYCLE_LIMIT = 600_000;   // ~1750 items
  localparam int TAIL_CYCLES = 40;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 140;
  localparam int PREDICTED   = -1;        // table row checked against the model
  localparam int NUM_ROWS    = 48;

  // indexes past the last register; writes there must be dropped
  localparam logic [pds_pkg::CfgIdxW-1:0] REG_FIRST_UNMAPPED =
    pds_pkg::REG_MAX_STEP + pds_pkg::CfgIdxW'(1);
  localparam logic [pds_pkg::CfgIdxW-1:0] REG_UNMAPPED       = '1;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [pds_pkg::PctW-1:0]      raw_percent;
  logic [pds_pkg::TimeW-1:0]     time_ms;
  logic                          out_valid;
  logic                          out_ready;
  logic [pds_pkg::PctW-1:0]      shown_percent;
  logic                          cfg_we;
  logic [pds_pkg::CfgIdxW-1:0]   cfg_index;
  logic [pds_pkg::CfgDatW-1:0]   cfg_data;

  percent_display_smoother_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .raw_percent  (raw_percent),
    .time_ms      (time_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .shown_percent(shown_percent),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the smoother: register copy plus display state
  // --------------------------------------------------------------------------
  pds_pkg::cfg_t                 regs;
  logic                          seen;         // a value has been shown since reset
  logic [pds_pkg::TimeW-1:0]     last_stamp;   // timestamp of the previous item
  logic [pds_pkg::PctW-1:0]      disp;         // currently displayed percentage

  logic [pds_pkg::PctW-1:0]      pending_shown[$];   // shown_percent values still owed
  int                            err_count   = 0;
  int                            cycle_count = 0;

  // idling knobs, changed per phase; quiet turns all idling off
  bit                            quiet         = 1'b0;
  int                            in_gap_pct    = 0;
  int                            out_stall_pct = 0;
  int                            stall_left    = 0;

  function automatic logic [pds_pkg::PctW-1:0] pct_sat(input int v);
    if (v < 0) return '0;
    if (v > 100) return pds_pkg::PctMax;
    return pds_pkg::PctW'(v);
  endfunction

  // Advances the model by one reading and returns the value it shows.
  function automatic logic [pds_pkg::PctW-1:0] predict_shown(
    input logic [pds_pkg::PctW-1:0]  raw,
    input logic [pds_pkg::TimeW-1:0] stamp);
    logic [pds_pkg::TimeW-1:0] elapsed;
    int delta;
    int divisor;
    int limit;
    int step;
    elapsed    = stamp - last_stamp;    // modulo 2^32
    last_stamp = stamp;                 // stored on every path
    if (!seen || elapsed > regs.snap_interval_ms) begin
      disp = pct_sat(int'(raw));
      seen = 1'b1;
    end else if (raw <= regs.danger_level) begin
      disp = pct_sat(int'(raw));
    end else begin
      delta   = int'(raw) - int'(disp);
      divisor = (regs.gain_denominator == '0) ? 1 : int'(regs.gain_denominator);
      limit   = int'(regs.max_step);
      step    = (delta * int'(regs.gain_numerator)) / divisor;  // truncates toward zero
      // a tiny gain still moves the display by one
      if (step == 0 && delta != 0) step = (delta > 0) ? 1 : -1;
      if (step > limit) step = limit;
      if (step < -limit) step = -limit;
      disp = pct_sat(int'(disp) + step);
    end
    return disp;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One register write, one cycle of cfg_we; the model copy follows.
  task automatic write_reg(input logic [pds_pkg::CfgIdxW-1:0] idx,
                           input logic [pds_pkg::CfgDatW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      pds_pkg::REG_SNAP_INTERVAL: regs.snap_interval_ms = data;
      pds_pkg::REG_DANGER_LEVEL:  regs.danger_level     = data[pds_pkg::PctW-1:0];
      pds_pkg::REG_GAIN_NUM:      regs.gain_numerator   = data[pds_pkg::GainW-1:0];
      pds_pkg::REG_GAIN_DEN:      regs.gain_denominator = data[pds_pkg::GainW-1:0];
      pds_pkg::REG_MAX_STEP:      regs.max_step         = data[pds_pkg::PctW-1:0];
      default: ;   // unmapped index, ignored
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drops valid and waits until every owed result has been taken, so the
  // block is idle and registers may change.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_shown.size() == 0);
  endtask

  // Offers one reading; valid stays up after acceptance until the next call
  // either replaces the payload or drops valid for a gap.
  task automatic send_item(input logic [pds_pkg::PctW-1:0]  raw,
                           input logic [pds_pkg::TimeW-1:0] stamp,
                           input int pinned);
    int gap;
    logic [pds_pkg::PctW-1:0] model_val;
    gap = (!quiet && $urandom_range(0, 99) < in_gap_pct) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    raw_percent <= raw;
    time_ms     <= stamp;
    do @(posedge clk); while (!in_ready);
    model_val = predict_shown(raw, stamp);
    pending_shown.push_back((pinned == PREDICTED) ? model_val : pds_pkg::PctW'(pinned));
  endtask

  // Narrow registers ignore the upper data bits; sometimes fill them with junk.
  function automatic logic [pds_pkg::CfgDatW-1:0] dirty(input int value, input int width);
    logic [pds_pkg::CfgDatW-1:0] data;
    data = pds_pkg::CfgDatW'(value);
    if ($urandom_range(0, 4) == 0) data = data | ($urandom() << width);
    return data;
  endfunction

  // New settings for a phase, extremes favored.
  task automatic shuffle_settings();
    int v;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 1;
        2: v = 60000;
        3: v = $urandom_range(0, 5000);
        4: v = -1;               // all ones: never snaps
        default: v = $urandom();
      endcase
      write_reg(pds_pkg::REG_SNAP_INTERVAL, pds_pkg::CfgDatW'(v));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 10;
        2: v = 100;
        3: v = 127;              // above 100: everything bypasses
        default: v = $urandom_range(0, 100);
      endcase
      write_reg(pds_pkg::REG_DANGER_LEVEL, dirty(v, pds_pkg::PctW));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 1;
        2: v = 255;
        3: v = $urandom_range(0, 255);
        default: v = $urandom_range(0, 8);
      endcase
      write_reg(pds_pkg::REG_GAIN_NUM, dirty(v, pds_pkg::GainW));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 0;                // treated as one
        1: v = 1;
        2: v = 255;
        3: v = $urandom_range(1, 255);
        default: v = $urandom_range(1, 16);
      endcase
      write_reg(pds_pkg::REG_GAIN_DEN, dirty(v, pds_pkg::GainW));
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0: v = 0;                // display holds on the smoothing path
        1: v = 1;
        2: v = 100;
        3: v = 127;
        default: v = $urandom_range(1, 20);
      endcase
      write_reg(pds_pkg::REG_MAX_STEP, dirty(v, pds_pkg::PctW));
    end
    if ($urandom_range(0, 3) == 0)
      write_reg(pds_pkg::CfgIdxW'($urandom_range(REG_FIRST_UNMAPPED, REG_UNMAPPED)),
                $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit                            is_cfg;
    logic [pds_pkg::CfgIdxW-1:0]   reg_idx;
    logic [pds_pkg::CfgDatW-1:0]   value;
    logic [pds_pkg::PctW-1:0]      raw;
    logic [pds_pkg::TimeW-1:0]     stamp;
    int                            pinned;    // expected shown value, or PREDICTED
  } script_row_t;

  function automatic script_row_t cfg_row(input logic [pds_pkg::CfgIdxW-1:0] idx,
                                          input logic [pds_pkg::CfgDatW-1:0] value);
    return '{1'b1, idx, value, '0, '0, PREDICTED};
  endfunction

  function automatic script_row_t item_row(input int raw,
                                           input logic [pds_pkg::TimeW-1:0] stamp,
                                           input int pinned);
    return '{1'b0, pds_pkg::REG_SNAP_INTERVAL, '0, pds_pkg::PctW'(raw), stamp, pinned};
  endfunction

  script_row_t script[NUM_ROWS];

  // --------------------------------------------------------------------------
  // Result side: random backpressure and the check
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0 && !quiet) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(0, 13);   // start a stall burst
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [pds_pkg::PctW-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_shown.size() == 0) begin
        $display("%0t: unexpected shown_percent item, expected none got %0d",
                 $time, shown_percent);
        err_count++;
      end else begin
        want = pending_shown.pop_front();
        if (shown_percent !== want) begin
          $display("%0t: shown_percent expected %0d got %0d", $time, want, shown_percent);
          err_count++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL percent_display_smoother_unit");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [pds_pkg::TimeW-1:0] stamp_now;
    int                        raw_v;
    int                        pick;
    rst         = 1'b1;
    in_valid    = 1'b0;
    raw_percent = '0;
    time_ms     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    regs        = '{snap_interval_ms: 60000, danger_level: 10, gain_numerator: 1,
                    gain_denominator: 4, max_step: 5};
    seen        = 1'b0;
    last_stamp  = '0;
    disp        = '0;

    script = '{
      // reset settings: snap 60000, danger 10, gain 1/4, step 5
      item_row(50,  32'd1000,        50),          // first item shows raw
      item_row(60,  32'd2000,        PREDICTED),
      item_row(10,  32'd3000,        10),          // at danger level: bypass
      item_row(11,  32'd4000,        PREDICTED),   // zero quotient becomes +1
      item_row(100, 32'd64000,       PREDICTED),   // gap equal to interval: no snap
      item_row(100, 32'd124001,      100),         // gap one past interval: snap
      item_row(127, 32'd124002,      100),         // raw above 100 saturates
      item_row(0,   32'd124003,      0),
      item_row(127, 32'hFFFF_FFF0,   100),         // huge gap snaps, saturated
      item_row(20,  32'h0000_0010,   PREDICTED),   // timestamp wraps, short gap
      cfg_row(pds_pkg::REG_SNAP_INTERVAL, 32'd0),
      cfg_row(pds_pkg::REG_DANGER_LEVEL,  32'd0),
      cfg_row(pds_pkg::REG_GAIN_NUM,      32'd255),
      cfg_row(pds_pkg::REG_GAIN_DEN,      32'd0),           // zero divisor acts as one
      cfg_row(pds_pkg::REG_MAX_STEP,      32'd127),
      item_row(0,   32'h0000_0010,   0),           // zero gap never snaps
      item_row(100, 32'h0000_0010,   PREDICTED),
      item_row(1,   32'h0000_0011,   1),           // any gap snaps at interval 0
      cfg_row(pds_pkg::REG_SNAP_INTERVAL, 32'hFFFF_FFFF),
      cfg_row(pds_pkg::REG_DANGER_LEVEL,  32'd127),         // danger above 100
      item_row(120, 32'h0000_0000,   100),
      item_row(5,   32'h8000_0000,   5),
      cfg_row(pds_pkg::REG_DANGER_LEVEL,  32'd100),
      cfg_row(pds_pkg::REG_GAIN_NUM,      32'd0),
      cfg_row(pds_pkg::REG_GAIN_DEN,      32'd255),
      cfg_row(pds_pkg::REG_MAX_STEP,      32'd0),           // step clamped to zero
      item_row(101, 32'h8000_0001,   PREDICTED),
      cfg_row(pds_pkg::REG_MAX_STEP,      32'd1),
      cfg_row(pds_pkg::REG_GAIN_NUM,      32'd255),
      item_row(127, 32'h8000_0002,   PREDICTED),
      cfg_row(REG_UNMAPPED,               32'd0),           // must be dropped
      cfg_row(pds_pkg::REG_MAX_STEP,      32'd100),
      cfg_row(pds_pkg::REG_GAIN_NUM,      32'd3),
      cfg_row(pds_pkg::REG_GAIN_DEN,      32'd2),
      cfg_row(pds_pkg::REG_DANGER_LEVEL,  32'd0),
      item_row(100, 32'h8000_0003,   PREDICTED),
      item_row(1,   32'h8000_0004,   PREDICTED),   // large negative step
      item_row(3,   32'h8000_0005,   PREDICTED),
      item_row(2,   32'h8000_0006,   PREDICTED),
      cfg_row(pds_pkg::REG_GAIN_NUM,      32'd1),
      cfg_row(pds_pkg::REG_GAIN_DEN,      32'd255),
      item_row(50,  32'h8000_0007,   PREDICTED),
      item_row(1,   32'h8000_0008,   PREDICTED),   // zero quotient becomes -1
      // back to reset settings
      cfg_row(pds_pkg::REG_SNAP_INTERVAL, 32'd60000),
      cfg_row(pds_pkg::REG_DANGER_LEVEL,  32'd10),
      cfg_row(pds_pkg::REG_GAIN_NUM,      32'd1),
      cfg_row(pds_pkg::REG_GAIN_DEN,      32'd4),
      cfg_row(pds_pkg::REG_MAX_STEP,      32'd5)
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    in_gap_pct    = 20;
    out_stall_pct = 20;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_item(script[i].raw, script[i].stamp, script[i].pinned);
      end
    end

    // Random phases. Timestamps mostly move forward by no more than the snap
    // interval so the smoothing path gets most of the traffic; the rest sits
    // right at the interval, jumps anywhere, repeats, or steps backwards.
    stamp_now = $urandom();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        shuffle_settings();
      end
      quiet = (ph == NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: in_gap_pct = 0;
        1: in_gap_pct = 15;
        default: in_gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: out_stall_pct = 0;
        1: out_stall_pct = 15;
        default: out_stall_pct = 50;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          if (regs.snap_interval_ms < 3000)
            stamp_now += $urandom_range(0, regs.snap_interval_ms);
          else
            stamp_now += $urandom_range(0, 3000);
        end else if (pick < 75) begin
          stamp_now += regs.snap_interval_ms + $urandom_range(0, 2) - 1;  // at the edge
        end else if (pick < 85) begin
          stamp_now = $urandom();
        end else if (pick < 90) begin
          // same timestamp again
        end else begin
          stamp_now -= $urandom_range(1, 100);   // backwards reads as a long gap
        end

        pick = $urandom_range(0, 99);
        if (pick < 50) raw_v = int'(disp) + $urandom_range(0, 40) - 20;
        else if (pick < 65) raw_v = int'(regs.danger_level) + $urandom_range(0, 4) - 2;
        else if (pick < 90) raw_v = $urandom_range(0, 100);
        else raw_v = $urandom_range(101, 127);
        if (raw_v < 0) raw_v = 0;
        if (raw_v > 127) raw_v = 127;

        send_item(pds_pkg::PctW'(raw_v), stamp_now, PREDICTED);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS percent_display_smoother_unit");
    end else begin
      $display("FAIL percent_display_smoother_unit");
    end
    $finish;
  end

endmodule
